// ===== rtl/pip_pkg.sv =====
// Shared constants, codes and item types of the point-in-polygon block.
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_DUP     = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_CLEARED = 2'd3;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic             inside_res;
    logic [1:0]       status;
    logic [CNT_W-1:0] vertex_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/point_in_polygon_test.sv =====
// Top level: vertex memory, scan sequencer and crossing-test pipeline.
// An add walks the N stored vertices; a query reads N+1 entries (the last vertex first).
// The single read port of the vertex memory delivers one vertex per cycle.
// Clear, unused kinds and early-out queries skip the scan, as does an add to an empty table.
// The next item is accepted as soon as the result appears, even while that result waits.
// Reset clears the vertex count and the bounding box; the memory is not cleared.
`default_nettype none

module point_in_polygon_test (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  pip_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output pip_pkg::out_item_t  out_item
);

  localparam int CW = pip_pkg::COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_DRAIN, S_ADD_END, S_RESP
  } state_t;

  state_t state_r;

  logic [1:0]                  kind_r;
  logic signed [CW-1:0]        px_r, py_r;
  logic [pip_pkg::CNT_W-1:0]   count_r;
  logic signed [CW-1:0]        min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [CW-1:0]        first_x_r, first_y_r;
  logic [pip_pkg::CNT_W-1:0]   iss_r;
  logic                        rd_vld_r, rd_first_r;
  logic signed [CW-1:0]        prev_x_r, prev_y_r;
  logic                        dup_r, par_r;
  logic                        p1_vld_r, p1_cond_r, p1_dypos_r;
  logic signed [pip_pkg::PROD_W-1:0] p1_lhs_r, p1_rhs_r;
  logic                        res_inside_r;
  logic [1:0]                  res_status_r;
  logic                        out_valid_r;
  pip_pkg::out_item_t          out_item_r;

  // Vertex memory: x in the upper half, y in the lower half of each word.
  logic [2*CW-1:0]             vmem [pip_pkg::MAX_VERTICES];
  logic [2*CW-1:0]             mem_q;
  logic                        mem_we;
  logic [pip_pkg::IDX_W-1:0]   mem_wa, mem_ra;

  logic                        is_query, iss_last, outside, full;
  logic signed [CW-1:0]        q_x, q_y;
  logic                        cond_c, cross_c;
  logic signed [pip_pkg::DIFF_W-1:0] dx_c, dy_c, ex_c, ey_c;
  logic signed [pip_pkg::PROD_W-1:0] lhs_c, rhs_c;

  assign is_query = (kind_r == pip_pkg::KIND_QUERY);
  assign full     = (count_r == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));
  assign outside  = (px_r < min_x_r) || (py_r < min_y_r) ||
                    (px_r > max_x_r) || (py_r > max_y_r);

  // A query first reads the last vertex so that edge (last, 0) comes first.
  always_comb begin
    if (is_query) begin
      if (iss_r == '0) begin
        mem_ra = pip_pkg::IDX_W'(count_r - 1'b1);
      end else begin
        mem_ra = pip_pkg::IDX_W'(iss_r - 1'b1);
      end
      iss_last = (iss_r == count_r);
    end else begin
      mem_ra   = pip_pkg::IDX_W'(iss_r);
      iss_last = (iss_r == count_r - 1'b1);
    end
  end

  assign mem_we = (state_r == S_ADD_END) && !dup_r && !full;
  assign mem_wa = pip_pkg::IDX_W'(count_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[mem_wa] <= {px_r, py_r};
    end
    mem_q <= vmem[mem_ra];
  end

  assign q_x = mem_q[2*CW-1:CW];
  assign q_y = mem_q[CW-1:0];

  // Edge from the previous vertex (j) to the one just read (i).
  assign cond_c = ((q_y <= py_r) && (py_r < prev_y_r)) ||
                  ((prev_y_r <= py_r) && (py_r < q_y));
  assign dy_c   = pip_pkg::DIFF_W'(prev_y_r) - pip_pkg::DIFF_W'(q_y);
  assign dx_c   = pip_pkg::DIFF_W'(px_r) - pip_pkg::DIFF_W'(q_x);
  assign ex_c   = pip_pkg::DIFF_W'(prev_x_r) - pip_pkg::DIFF_W'(q_x);
  assign ey_c   = pip_pkg::DIFF_W'(py_r) - pip_pkg::DIFF_W'(q_y);
  assign lhs_c  = pip_pkg::PROD_W'(dx_c) * pip_pkg::PROD_W'(dy_c);
  assign rhs_c  = pip_pkg::PROD_W'(ex_c) * pip_pkg::PROD_W'(ey_c);

  // The sign of dy decides which way the cross-multiplied compare goes.
  assign cross_c = p1_dypos_r ? (p1_lhs_r < p1_rhs_r) : (p1_rhs_r < p1_lhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_x_r     <= '0;
      max_x_r     <= '0;
      min_y_r     <= '0;
      max_y_r     <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      rd_first_r  <= 1'b0;
      p1_vld_r    <= 1'b0;
      dup_r       <= 1'b0;
      par_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= 1'b0;

      // Read stage: duplicate compare for adds, edge products for queries.
      if (rd_vld_r) begin
        if (is_query) begin
          prev_x_r <= q_x;
          prev_y_r <= q_y;
        end else if ((q_x == px_r) && (q_y == py_r)) begin
          dup_r <= 1'b1;
        end
      end
      p1_vld_r   <= rd_vld_r && !rd_first_r && is_query;
      p1_cond_r  <= cond_c;
      p1_dypos_r <= (dy_c > 0);
      p1_lhs_r   <= lhs_c;
      p1_rhs_r   <= rhs_c;

      if (p1_vld_r && p1_cond_r && cross_c) begin
        par_r <= !par_r;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_item.kind;
            px_r    <= in_item.x_coord;
            py_r    <= in_item.y_coord;
            state_r <= S_START;
          end
        end

        S_START: begin
          res_inside_r <= 1'b0;
          res_status_r <= pip_pkg::STAT_DONE;
          iss_r        <= '0;
          dup_r        <= 1'b0;
          par_r        <= 1'b0;
          priority case (kind_r)
            pip_pkg::KIND_ADD: begin
              state_r <= (count_r == '0) ? S_ADD_END : S_SCAN;
            end
            pip_pkg::KIND_QUERY: begin
              if ((count_r < pip_pkg::CNT_W'(2)) || outside) begin
                state_r <= S_RESP;
              end else begin
                state_r <= S_SCAN;
              end
            end
            pip_pkg::KIND_CLEAR: begin
              count_r      <= '0;
              min_x_r      <= '0;
              max_x_r      <= '0;
              min_y_r      <= '0;
              max_y_r      <= '0;
              res_status_r <= pip_pkg::STAT_CLEARED;
              state_r      <= S_RESP;
            end
            default: begin
              state_r <= S_RESP;
            end
          endcase
        end

        S_SCAN: begin
          rd_vld_r   <= 1'b1;
          rd_first_r <= is_query && (iss_r == '0);
          iss_r      <= iss_r + 1'b1;
          if (iss_last) begin
            state_r <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          if (!rd_vld_r && !p1_vld_r) begin
            if (is_query) begin
              res_inside_r <= par_r;
              state_r      <= S_RESP;
            end else begin
              state_r <= S_ADD_END;
            end
          end
        end

        S_ADD_END: begin
          if (dup_r) begin
            res_status_r <= pip_pkg::STAT_DUP;
          end else if (full) begin
            res_status_r <= pip_pkg::STAT_FULL;
          end else begin
            count_r <= count_r + 1'b1;
            if (count_r == '0) begin
              first_x_r <= px_r;
              first_y_r <= py_r;
            end else if (count_r == pip_pkg::CNT_W'(1)) begin
              // Second vertex: the box is first formed from both.
              min_x_r <= (px_r < first_x_r) ? px_r : first_x_r;
              max_x_r <= (px_r > first_x_r) ? px_r : first_x_r;
              min_y_r <= (py_r < first_y_r) ? py_r : first_y_r;
              max_y_r <= (py_r > first_y_r) ? py_r : first_y_r;
            end else begin
              if (px_r < min_x_r) min_x_r <= px_r;
              if (px_r > max_x_r) max_x_r <= px_r;
              if (py_r < min_y_r) min_y_r <= py_r;
              if (py_r > max_y_r) max_y_r <= py_r;
            end
          end
          state_r <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r             <= 1'b1;
            out_item_r.inside_res   <= res_inside_r;
            out_item_r.status       <= res_status_r;
            out_item_r.vertex_count <= count_r;
            state_r                 <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/pip_checker.sv =====
// Port-level checker for the point-in-polygon block and its bind.
`default_nettype none

module pip_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input pip_pkg::out_item_t out_item
);

  // A result held back by the receiver stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Only a query can report a point inside, and it reports done.
  a_inside_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.inside_res |-> out_item.status == pip_pkg::STAT_DONE)
    else $error("inside reported with non-done status");

  // A cleared table reports no vertices.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == pip_pkg::STAT_CLEARED) |->
      (out_item.vertex_count == '0) && !out_item.inside_res)
    else $error("clear left vertices");

  // A dropped vertex means the table really is full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == pip_pkg::STAT_FULL) |->
      out_item.vertex_count == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES))
    else $error("full reported below capacity");

  // The block works one item at a time, so an accepted item stalls the input.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was accepted");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

`default_nettype wire
